>>> design/frt_pkg.sv
// Shared types, sizes and helpers for the IPv6 flow route table.
package frt_pkg;

	localparam int ROUTE_SLOTS      = 16;
	localparam int LEAVES_PER_ROUTE = 4;
	localparam int LEAF_TOTAL       = ROUTE_SLOTS * LEAVES_PER_ROUTE;
	localparam int RIDX_W = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
	localparam int LJ_W   = (LEAVES_PER_ROUTE > 1) ? $clog2(LEAVES_PER_ROUTE) : 1;
	localparam int LIDX_W = (LEAF_TOTAL > 1) ? $clog2(LEAF_TOTAL) : 1;
	localparam int CNT_W  = (RIDX_W > LJ_W) ? RIDX_W : LJ_W;
	localparam logic [7:0] MAX_LEN = 8'd128;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RSCAN,
		ST_RDRAIN,
		ST_DECIDE,
		ST_LSCAN,
		ST_LDRAIN,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic [127:0] addr;
		logic [7:0]   len;
		logic [127:0] gw;
		logic [7:0]   port;
	} route_ent_t;

	typedef struct packed {
		logic [19:0]  label;
		logic [127:0] gw;
	} leaf_ent_t;

	localparam int ROUTE_W = $bits(route_ent_t);
	localparam int LEAF_W  = $bits(leaf_ent_t);

	// prefix mask for lengths 0..128
	function automatic logic [127:0] pfx_mask(input logic [7:0] len);
		logic [127:0] m;
		if (len == 8'd0) begin
			m = '0;
		end else begin
			m = {128{1'b1}} << (MAX_LEN - len);
		end
		return m;
	endfunction

endpackage

>>> design/frt_ram.sv
// Single-port-write, registered-read synchronous RAM.
module frt_ram #(
	parameter int W  = 8,
	parameter int D  = 16,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/ipv6_flow_route_table.sv
// Top level: IPv6 longest-prefix route table with flow-label leaves.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  in      | in_valid / in_ready | command dst_high dst_low prefix_len flow_id
//          |                     | gw_high gw_low port_index
//  out     | out_valid/out_ready | found out_gw_high out_gw_low out_port
//          |                     | match_len table_full
//
// One command at a time; the route RAM is walked one entry per cycle and then,
// when a route matched and the command is a lookup or carries a flow label,
// the matched route's leaves in the leaf RAM. in_ready returns together with
// the new result on out_valid.
// Reset clears the used/valid flops and the default route; RAM contents are
// only read behind those flags, so no clearing pass is needed.
// A result waits in the output register; the next command is accepted
// meanwhile and stalls only at its write-back if the result is still pending.
module ipv6_flow_route_table import frt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [1:0]   command,
	input  logic [63:0]  dst_high,
	input  logic [63:0]  dst_low,
	input  logic [7:0]   prefix_len,
	input  logic [19:0]  flow_id,
	input  logic [63:0]  gw_high,
	input  logic [63:0]  gw_low,
	input  logic [7:0]   port_index,
	output logic         out_valid,
	input  logic         out_ready,
	output logic         found,
	output logic [63:0]  out_gw_high,
	output logic [63:0]  out_gw_low,
	output logic [7:0]   out_port,
	output logic [7:0]   match_len,
	output logic         table_full
);

	state_t state_q, state_d;

	// command registers
	cmd_t         cmd_q;
	logic [127:0] dst_q;
	logic [7:0]   len_q;
	logic [19:0]  fl_q;
	logic [127:0] gw_q;
	logic [7:0]   port_q;

	logic [CNT_W-1:0] cnt_q;
	logic             rvld_s1, lvld_s1;
	logic [RIDX_W-1:0] ridx_s1;
	logic [LJ_W-1:0]   lj_s1;

	logic              hit_q;
	logic [RIDX_W-1:0] idx_q;
	route_ent_t        ent_q;
	logic              lhit_q;
	logic [LJ_W-1:0]   lslot_q;
	leaf_ent_t         lent_q;

	logic [ROUTE_SLOTS-1:0] route_used_q, route_valid_q;
	logic [LEAF_TOTAL-1:0]  leaf_used_q;
	logic        dflt_valid_q;
	logic [127:0] dflt_gw_q;
	logic [7:0]   dflt_port_q;

	logic         out_valid_q, found_q, full_q;
	logic [127:0] ogw_q;
	logic [7:0]   oport_q, olen_q;

	// RAM ports
	logic              r_we, l_we;
	logic [RIDX_W-1:0] r_waddr, r_raddr;
	logic [LIDX_W-1:0] l_waddr, l_raddr;
	route_ent_t        r_wdata, r_rdata;
	leaf_ent_t         l_wdata, l_rdata;

	frt_ram #(.W(ROUTE_W), .D(ROUTE_SLOTS), .AW(RIDX_W)) u_route_ram (
		.clk, .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
		.raddr(r_raddr), .rdata(r_rdata)
	);

	frt_ram #(.W(LEAF_W), .D(LEAF_TOTAL), .AW(LIDX_W)) u_leaf_ram (
		.clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(l_raddr), .rdata(l_rdata)
	);

	logic [127:0] pfx;
	logic         in_beat, out_free, exec_go;
	logic         need_leaf;

	assign pfx      = dst_q & pfx_mask(len_q);
	assign in_beat  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign exec_go  = (state_q == ST_EXEC) && out_free;
	assign need_leaf = hit_q && ((cmd_q == CMD_LOOKUP) || (fl_q != 20'd0));

	assign r_raddr = cnt_q[RIDX_W-1:0];
	assign l_raddr = LIDX_W'(int'(idx_q) * LEAVES_PER_ROUTE + int'(cnt_q[LJ_W-1:0]));

	function automatic logic [LIDX_W-1:0] leaf_at(input logic [RIDX_W-1:0] r,
			input int j);
		return LIDX_W'(int'(r) * LEAVES_PER_ROUTE + j);
	endfunction

	// free slot search over the flags
	logic              rfree_ok, lfree_ok;
	logic [RIDX_W-1:0] rfree;
	logic [LJ_W-1:0]   lfree;
	always_comb begin
		rfree_ok = 1'b0;
		rfree    = '0;
		for (int s = 0; s < ROUTE_SLOTS; s++) begin
			if (!route_used_q[s]) begin
				rfree_ok = 1'b1;
				rfree    = RIDX_W'(s);
			end
		end
		lfree_ok = 1'b0;
		lfree    = '0;
		for (int j = 0; j < LEAVES_PER_ROUTE; j++) begin
			if (!leaf_used_q[leaf_at(idx_q, j)]) begin
				lfree_ok = 1'b1;
				lfree    = LJ_W'(j);
			end
		end
	end

	// route and leaf entry evaluation
	logic r_match, r_take, l_match;
	always_comb begin
		if (cmd_q == CMD_LOOKUP) begin
			r_match = route_used_q[ridx_s1] &&
				((dst_q & pfx_mask(r_rdata.len)) == r_rdata.addr);
			r_take  = r_match && (!hit_q || (r_rdata.len > ent_q.len));
		end else begin
			r_match = route_used_q[ridx_s1] && (r_rdata.len == len_q) &&
				(r_rdata.addr == pfx);
			r_take  = r_match && !hit_q;
		end
		r_take  = r_take && rvld_s1;
		l_match = lvld_s1 && leaf_used_q[leaf_at(idx_q, int'(lj_s1))] &&
			(l_rdata.label == fl_q);
	end

	// write-back decode
	logic add_len0, add_old, add_new, del_len0, del_old;
	logic [LJ_W-1:0] wslot;
	always_comb begin
		add_len0 = (cmd_q == CMD_ADD) && (len_q == 8'd0);
		add_old  = (cmd_q == CMD_ADD) && (len_q != 8'd0) && hit_q;
		add_new  = (cmd_q == CMD_ADD) && (len_q != 8'd0) && !hit_q;
		del_len0 = (cmd_q == CMD_DELETE) && (len_q == 8'd0);
		del_old  = (cmd_q == CMD_DELETE) && (len_q != 8'd0) && hit_q;
		wslot    = lhit_q ? lslot_q : lfree;

		r_we    = 1'b0;
		r_waddr = idx_q;
		r_wdata = ent_q;
		l_we    = 1'b0;
		l_waddr = leaf_at(idx_q, int'(wslot));
		l_wdata = '{label: fl_q, gw: gw_q};
		if (exec_go) begin
			if (add_old) begin
				r_wdata.port = port_q;
				if (fl_q == 20'd0) begin
					r_we       = 1'b1;
					r_wdata.gw = gw_q;
				end else if (lhit_q || lfree_ok) begin
					r_we = 1'b1;
					l_we = 1'b1;
				end
			end else if (add_new && rfree_ok) begin
				r_we    = 1'b1;
				r_waddr = rfree;
				r_wdata = '{addr: pfx, len: len_q, gw: gw_q, port: port_q};
				l_we    = (fl_q != 20'd0);
				l_waddr = leaf_at(rfree, 0);
			end
		end
	end

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_RSCAN;
			end
			ST_RSCAN: begin
				if (cnt_q == CNT_W'(ROUTE_SLOTS - 1)) state_d = ST_RDRAIN;
			end
			ST_RDRAIN: state_d = ST_DECIDE;
			ST_DECIDE: state_d = need_leaf ? ST_LSCAN : ST_EXEC;
			ST_LSCAN: begin
				if (cnt_q == CNT_W'(LEAVES_PER_ROUTE - 1)) state_d = ST_LDRAIN;
			end
			ST_LDRAIN: state_d = ST_EXEC;
			ST_EXEC: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// command capture and scan datapath
	always_ff @(posedge clk) begin
		if (in_beat) begin
			cmd_q  <= cmd_t'(command);
			dst_q  <= {dst_high, dst_low};
			len_q  <= (prefix_len > MAX_LEN) ? MAX_LEN : prefix_len;
			fl_q   <= flow_id;
			gw_q   <= {gw_high, gw_low};
			port_q <= port_index;
		end
		ridx_s1 <= cnt_q[RIDX_W-1:0];
		lj_s1   <= cnt_q[LJ_W-1:0];
		if (r_take) begin
			idx_q <= ridx_s1;
			ent_q <= r_rdata;
		end
		if (l_match && !lhit_q) begin
			lslot_q <= lj_s1;
			lent_q  <= l_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			rvld_s1 <= 1'b0;
			lvld_s1 <= 1'b0;
			hit_q   <= 1'b0;
			lhit_q  <= 1'b0;
		end else begin
			rvld_s1 <= (state_q == ST_RSCAN);
			lvld_s1 <= (state_q == ST_LSCAN);
			if ((state_q == ST_RSCAN) || (state_q == ST_LSCAN)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (state_q == ST_RDRAIN) cnt_q <= '0;
			if (in_beat) begin
				cnt_q  <= '0;
				hit_q  <= 1'b0;
				lhit_q <= 1'b0;
			end
			if (r_take) hit_q <= 1'b1;
			if (l_match) lhit_q <= 1'b1;
		end
	end

	// table flags and default route
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_used_q  <= '0;
			route_valid_q <= '0;
			leaf_used_q   <= '0;
			dflt_valid_q  <= 1'b0;
			dflt_gw_q     <= '0;
			dflt_port_q   <= '0;
		end else begin
			// leaf delete frees every matching leaf during the walk
			if (l_match && (cmd_q == CMD_DELETE)) begin
				leaf_used_q[leaf_at(idx_q, int'(lj_s1))] <= 1'b0;
			end
			if (exec_go) begin
				if (add_len0) begin
					dflt_valid_q <= 1'b1;
					dflt_gw_q    <= gw_q;
					dflt_port_q  <= port_q;
				end
				if (del_len0) dflt_valid_q <= 1'b0;
				if (add_old) begin
					if (fl_q == 20'd0) begin
						route_valid_q[idx_q] <= 1'b1;
					end else if (lhit_q || lfree_ok) begin
						leaf_used_q[leaf_at(idx_q, int'(wslot))] <= 1'b1;
					end
				end
				if (add_new && rfree_ok) begin
					route_used_q[rfree]  <= 1'b1;
					route_valid_q[rfree] <= (fl_q == 20'd0);
					for (int j = 0; j < LEAVES_PER_ROUTE; j++) begin
						leaf_used_q[leaf_at(rfree, j)] <= (j == 0) && (fl_q != 20'd0);
					end
				end
				if (del_old) begin
					logic any_leaf;
					any_leaf = 1'b0;
					for (int j = 0; j < LEAVES_PER_ROUTE; j++) begin
						any_leaf = any_leaf || leaf_used_q[leaf_at(idx_q, j)];
					end
					if (fl_q == 20'd0) route_valid_q[idx_q] <= 1'b0;
					if (!any_leaf && ((fl_q == 20'd0) || !route_valid_q[idx_q])) begin
						route_used_q[idx_q] <= 1'b0;
					end
				end
			end
		end
	end

	// result register
	logic         res_found, res_full;
	logic [127:0] res_gw;
	logic [7:0]   res_port, res_len;
	always_comb begin
		res_found = 1'b0;
		res_full  = 1'b0;
		res_gw    = '0;
		res_port  = '0;
		res_len   = '0;
		case (cmd_q)
			CMD_LOOKUP: begin
				if (dflt_valid_q) begin
					res_found = 1'b1;
					res_gw    = dflt_gw_q;
					res_port  = dflt_port_q;
				end
				if (hit_q && (lhit_q || route_valid_q[idx_q])) begin
					res_found = 1'b1;
					res_gw    = lhit_q ? lent_q.gw : ent_q.gw;
					res_port  = ent_q.port;
					res_len   = ent_q.len;
				end
			end
			CMD_ADD: begin
				res_full = (add_old && (fl_q != 20'd0) && !lhit_q && !lfree_ok) ||
					(add_new && !rfree_ok);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			found_q <= res_found;
			full_q  <= res_full;
			ogw_q   <= res_gw;
			oport_q <= res_port;
			olen_q  <= res_len;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign table_full  = full_q;
	assign out_gw_high = ogw_q[127:64];
	assign out_gw_low  = ogw_q[63:0];
	assign out_port    = oport_q;
	assign match_len   = olen_q;

endmodule

>>> design/frt_checker.sv
// Port-level checks for the route table, bound to the top level.
module frt_port_props (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        found,
	input logic [63:0] out_gw_high,
	input logic [63:0] out_gw_low,
	input logic [7:0]  out_port,
	input logic [7:0]  match_len,
	input logic        table_full
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command taken while engine busy");

	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(found && table_full))
		else $error("lookup hit and table_full together");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> (out_gw_high == 64'd0) && (out_gw_low == 64'd0) &&
			(out_port == 8'd0) && (match_len == 8'd0))
		else $error("miss result carries data");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> match_len <= 8'd128)
		else $error("match_len out of range");

endmodule

bind ipv6_flow_route_table frt_port_props u_frt_port_props (.*);
